/* sv/ifla_pkg.sv */
// shared types and constants for the identifier allocator
`timescale 1ns / 1ps
`default_nettype none

package ifla_pkg;

    localparam int LOCK_ID_W = 6;
    localparam int GRANT_W   = 5;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

endpackage

`default_nettype wire

/* sv/id_free_list_allocator_core.sv */
// identifier allocator: free-id stack with a taken bit per identifier
//
// input channel (in_valid / in_stall) carries one request word: op selects
// allocate, free lock_id or check lock_id. every request word yields exactly
// one result word on the output channel (out_valid / out_stall): ok and
// granted_id, the latter nonzero only for a successful allocate.
// a request is captured in an input register together with its taken bit
// (read from the taken-bit memory at accept time), resolved in one pass of
// combinational logic, and written into the result register, which drives
// out_valid; one request is taken every cycle while in_stall stays low.
// the free stack lives in a memory whose top entry is read ahead
// into a register, so back-to-back allocates and frees see the current top.
// stack entries never written since reset read as their own index, tracked
// by a high-water mark on the stack pointer, so that memory needs no clear.
// after reset the taken-bit memory is cleared one entry a cycle, over all
// POOL_SIZE entries; in_stall stays high during that sweep.
// when out_stall holds the result, the input register still takes one more
// request; after that in_stall rises until the result word is taken.
`timescale 1ns / 1ps
`default_nettype none

module id_free_list_allocator_core
    import ifla_pkg::*;
#(
    parameter int POOL_SIZE = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [LOCK_ID_W-1:0] lock_id,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      ok,
    output logic [GRANT_W-1:0]        granted_id
);

    localparam int IDW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int SPW   = $clog2(POOL_SIZE + 1);
    localparam int DEPTH = 2 ** IDW;
    localparam int CW    = ((IDW > LOCK_ID_W) ? IDW : LOCK_ID_W) + 1;
    localparam int GW    = (IDW > GRANT_W) ? IDW : GRANT_W;

    // storage
    logic [IDW-1:0] stack_mem [DEPTH];
    logic           taken_mem [DEPTH];

    // control state
    logic           clearing_reg;
    logic [SPW-1:0] clr_cnt_reg;
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_next;
    logic [SPW-1:0] hwm_reg;
    logic [SPW-1:0] hwm_next;

    // top-of-stack prefetch
    logic           top_init_reg;
    logic           top_byp_reg;
    logic [IDW-1:0] top_byp_data_reg;
    logic [IDW-1:0] top_rd_reg;
    logic [IDW-1:0] top;

    // input register
    logic                 s1_valid_reg;
    logic [OP_W-1:0]      s1_op_reg;
    logic [LOCK_ID_W-1:0] s1_id_reg;
    logic                 s1_tk_rd_reg;
    logic                 s1_tk_byp_reg;
    logic                 s1_tk_byp_data_reg;

    // result register
    logic               out_valid_reg;
    logic               ok_reg;
    logic [GRANT_W-1:0] granted_reg;

    logic               accept;
    logic               out_hold;
    logic               fire;
    logic [CW-1:0]      s1_id_ext;
    logic               s1_in_range;
    logic [IDW-1:0]     s1_addr;
    logic               s1_taken;
    logic               sp_full;
    logic [GW-1:0]      top_ext;
    logic               ok_next;
    logic [GRANT_W-1:0] granted_next;
    logic               do_alloc;
    logic               do_free;

    logic           stk_we;
    logic [IDW-1:0] stk_waddr;
    logic [IDW-1:0] stk_raddr;

    logic           tk_we;
    logic [IDW-1:0] tk_waddr;
    logic           tk_wdata;
    logic [CW-1:0]  in_id_ext;
    logic [IDW-1:0] tk_raddr;

    // handshake
    assign out_hold = out_valid_reg & out_stall;
    assign fire     = s1_valid_reg & ~out_hold;
    assign in_stall = clearing_reg | (s1_valid_reg & out_hold);
    assign accept   = in_valid & ~in_stall;

    // current top of stack: own index if never written, else memory or bypass
    always_comb
    begin
        priority if (top_byp_reg)
        begin
            top = top_byp_data_reg;
        end
        else if (top_init_reg)
        begin
            top = sp_reg[IDW-1:0];
        end
        else
        begin
            top = top_rd_reg;
        end
    end

    assign s1_id_ext   = CW'(s1_id_reg);
    assign s1_in_range = s1_id_ext < CW'(POOL_SIZE);
    assign s1_addr     = s1_id_ext[IDW-1:0];
    assign s1_taken    = s1_tk_byp_reg ? s1_tk_byp_data_reg : s1_tk_rd_reg;
    assign sp_full     = sp_reg == SPW'(POOL_SIZE);
    assign top_ext     = GW'(top);

    // request decode
    always_comb
    begin
        do_alloc     = 1'b0;
        do_free      = 1'b0;
        ok_next      = 1'b0;
        granted_next = '0;
        unique case (op_t'(s1_op_reg))
            OP_ALLOC:
            begin
                if (!sp_full)
                begin
                    do_alloc     = fire;
                    ok_next      = 1'b1;
                    granted_next = top_ext[GRANT_W-1:0];
                end
            end
            OP_FREE:
            begin
                if (s1_in_range && s1_taken && (sp_reg != '0))
                begin
                    do_free = fire;
                    ok_next = 1'b1;
                end
            end
            OP_CHECK:
            begin
                ok_next = s1_in_range & s1_taken;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // stack pointer, high-water mark and stack write
    always_comb
    begin
        sp_next = sp_reg;
        if (do_alloc)
        begin
            sp_next = sp_reg + SPW'(1);
        end
        else if (do_free)
        begin
            sp_next = sp_reg - SPW'(1);
        end
        hwm_next  = (sp_next > hwm_reg) ? sp_next : hwm_reg;
        stk_we    = do_free;
        stk_waddr = sp_next[IDW-1:0];
        stk_raddr = sp_next[IDW-1:0];
    end

    // taken-bit write port: clearing sweep, allocate sets, free clears
    always_comb
    begin
        tk_we    = 1'b0;
        tk_waddr = top;
        tk_wdata = 1'b0;
        priority if (clearing_reg)
        begin
            tk_we    = 1'b1;
            tk_waddr = clr_cnt_reg[IDW-1:0];
        end
        else if (do_alloc)
        begin
            tk_we    = 1'b1;
            tk_waddr = top;
            tk_wdata = 1'b1;
        end
        else if (do_free)
        begin
            tk_we    = 1'b1;
            tk_waddr = s1_addr;
        end
    end

    assign in_id_ext = CW'(lock_id);
    assign tk_raddr  = in_id_ext[IDW-1:0];

    // memories
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= s1_addr;
        end
        top_rd_reg       <= stack_mem[stk_raddr];
        top_byp_data_reg <= s1_addr;
    end

    always_ff @(posedge clk)
    begin
        if (tk_we)
        begin
            taken_mem[tk_waddr] <= tk_wdata;
        end
        if (accept)
        begin
            s1_tk_rd_reg       <= taken_mem[tk_raddr];
            s1_tk_byp_data_reg <= tk_wdata;
            s1_op_reg          <= op;
            s1_id_reg          <= lock_id;
        end
        if (fire)
        begin
            ok_reg      <= ok_next;
            granted_reg <= granted_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            sp_reg        <= '0;
            hwm_reg       <= '0;
            top_init_reg  <= 1'b1;
            top_byp_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_tk_byp_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + SPW'(1);
                if (clr_cnt_reg == SPW'(POOL_SIZE - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            sp_reg       <= sp_next;
            hwm_reg      <= hwm_next;
            top_byp_reg  <= stk_we;
            top_init_reg <= !(sp_next < hwm_next);

            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                s1_tk_byp_reg <= tk_we & (tk_waddr == tk_raddr);
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign granted_id = granted_reg;

endmodule

`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the identifier allocator core
`timescale 1ns / 1ps

module tb
    import ifla_pkg::*;
();

    localparam int POOL = 32;
    localparam int RANDOM_WORDS = 500;
    // op code that the block has no operation for
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

    // one request word as driven on the input channel
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [LOCK_ID_W-1:0] lock_id;
    } req_word_t;

    // one result word as seen on the output channel
    typedef struct packed {
        logic               ok;
        logic [GRANT_W-1:0] granted_id;
    } grant_word_t;

    // shadow of the allocator: free-id stack, taken bits, stack depth
    typedef struct packed {
        logic [POOL-1:0][GRANT_W-1:0] stack;
        logic [POOL-1:0]              taken;
        logic [6:0]                   depth;
    } pool_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [OP_W-1:0] op = OP_ALLOC;
    logic [LOCK_ID_W-1:0] lock_id = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic ok;
    logic [GRANT_W-1:0] granted_id;

    req_word_t   pending_words[$];
    grant_word_t expected_grants[$];
    pool_t       gen_pool;
    pool_t       dut_pool;

    int total_words = 0;
    int words_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    logic req_fire = 1'b0;
    logic hold_rx = 1'b0;
    logic quiet;

    id_free_list_allocator_core #(
        .POOL_SIZE(POOL)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .lock_id(lock_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ok(ok),
        .granted_id(granted_id)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // stretch with no idling on either side
    assign quiet = (words_accepted >= 300) && (words_accepted < 380);

    // pool as it stands after reset: stack entry i holds i, nothing taken
    function automatic pool_t fresh_pool();
        pool_t p;
        int i;
        for (i = 0; i < POOL; i++)
        begin
            p.stack[i] = GRANT_W'(i);
        end
        p.taken = '0;
        p.depth = '0;
        return p;
    endfunction

    // apply one request to a pool shadow, giving the result word and the new pool
    function automatic pool_t serve_request(input pool_t s, input req_word_t w,
                                            output grant_word_t r);
        pool_t n;
        logic [GRANT_W-1:0] g;
        n = s;
        r = '0;
        case (w.op)
            OP_ALLOC:
            begin
                // pool exhausted leaves everything as it is
                if (n.depth < POOL)
                begin
                    g = n.stack[n.depth];
                    n.taken[g] = 1'b1;
                    n.depth = n.depth + 7'd1;
                    r.ok = 1'b1;
                    r.granted_id = g;
                end
            end
            OP_FREE:
            begin
                // out of range, not taken or empty stack all fail
                if (w.lock_id < POOL)
                begin
                    if (n.taken[w.lock_id] && n.depth > 0)
                    begin
                        n.taken[w.lock_id] = 1'b0;
                        n.depth = n.depth - 7'd1;
                        n.stack[n.depth] = w.lock_id[GRANT_W-1:0];
                        r.ok = 1'b1;
                    end
                end
            end
            OP_CHECK:
            begin
                if (w.lock_id < POOL)
                begin
                    r.ok = n.taken[w.lock_id];
                end
            end
            default:
            begin
                // unknown op: no change, ok low
            end
        endcase
        return n;
    endfunction

    // queue a request word and keep the generator's shadow up to date
    task automatic add_word(input logic [OP_W-1:0] o, input logic [LOCK_ID_W-1:0] id);
        req_word_t w;
        grant_word_t unused;
        w.op = o;
        w.lock_id = id;
        gen_pool = serve_request(gen_pool, w, unused);
        pending_words.push_back(w);
        total_words++;
    endtask

    // identifier mostly inside the pool, sometimes beyond it
    function automatic logic [LOCK_ID_W-1:0] any_id();
        if ($urandom_range(0, 99) < 80)
            return LOCK_ID_W'($urandom_range(0, POOL - 1));
        return LOCK_ID_W'($urandom_range(POOL, 63));
    endfunction

    // some identifier that the generator believes is taken, else any in range
    function automatic logic [LOCK_ID_W-1:0] taken_id();
        int start;
        int k;
        int idx;
        start = $urandom_range(0, POOL - 1);
        for (k = 0; k < POOL; k++)
        begin
            idx = (start + k) % POOL;
            if (gen_pool.taken[idx])
                return LOCK_ID_W'(idx);
        end
        return LOCK_ID_W'($urandom_range(0, POOL - 1));
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // input side: a word is offered at the falling edge and held until taken
    always @(negedge clk)
    begin : drive_requests
        req_word_t w;
        if (rst_n)
        begin
            if (!in_valid || req_fire)
            begin
                if (pending_words.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= 19))
                begin
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    op <= w.op;
                    lock_id <= w.lock_id;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            // output side: random stalls plus the long hold-off
            out_stall <= hold_rx || (!quiet && $urandom_range(0, 99) < 19);
        end
    end

    // rising edge: record accepted requests, predict, check result words
    always @(posedge clk)
    begin : track_words
        req_word_t   w;
        grant_word_t want;
        grant_word_t got;
        req_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                w.op = op;
                w.lock_id = lock_id;
                dut_pool = serve_request(dut_pool, w, want);
                expected_grants.push_back(want);
                words_accepted <= words_accepted + 1;
            end
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                got.ok = ok;
                got.granted_id = granted_id;
                if (expected_grants.size() == 0)
                begin
                    report_mismatch($sformatf("result word with nothing pending ok=%0b id=%0d",
                                              got.ok, got.granted_id));
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
                    if (got.granted_id !== want.granted_id)
                        report_mismatch($sformatf("granted_id got %0d want %0d",
                                                  got.granted_id, want.granted_id));
                end
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin : rx_hold_off
        wait (words_accepted >= 150);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (80) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // run limit
    initial
    begin : watchdog
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        phase_kind_t kind;
        int len;
        int i;
        int roll;
        int phase;

        gen_pool = fresh_pool();
        dut_pool = fresh_pool();

        // directed: empty pool, range limits, unknown op, reuse after free
        add_word(OP_CHECK, 6'd0);
        add_word(OP_FREE, 6'd0);
        add_word(OP_FREE, 6'd63);
        add_word(OP_CHECK, 6'd32);
        add_word(OP_CHECK, 6'd63);
        add_word(OP_UNDEF, 6'd63);
        add_word(OP_ALLOC, 6'd0);
        add_word(OP_ALLOC, 6'd63);
        add_word(OP_ALLOC, 6'd31);
        add_word(OP_CHECK, 6'd0);
        add_word(OP_CHECK, 6'd2);
        add_word(OP_CHECK, 6'd31);
        add_word(OP_FREE, 6'd1);
        add_word(OP_CHECK, 6'd1);
        add_word(OP_ALLOC, 6'd0);
        add_word(OP_FREE, 6'd2);
        add_word(OP_FREE, 6'd2);
        add_word(OP_FREE, 6'd0);
        add_word(OP_FREE, 6'd32);
        add_word(OP_UNDEF, 6'd0);
        add_word(OP_CHECK, 6'd1);
        add_word(OP_FREE, 6'd31);

        // random part: phases that fill, drain or mix the pool
        phase = 0;
        while (total_words < 22 + RANDOM_WORDS)
        begin
            if (phase == 0)
            begin
                // run the pool dry first so exhaustion is always hit
                repeat (POOL + 3) add_word(OP_ALLOC, LOCK_ID_W'($urandom_range(0, 63)));
                kind = PH_DRAIN;
            end
            else
            begin
                kind = phase_kind_t'($urandom_range(0, 2));
            end
            len = $urandom_range(20, 60);
            for (i = 0; i < len; i++)
            begin
                roll = $urandom_range(0, 99);
                case (kind)
                    PH_FILL:
                        if (roll < 80)
                            add_word(OP_ALLOC, LOCK_ID_W'($urandom_range(0, 63)));
                        else if (roll < 90)
                            add_word(OP_CHECK, taken_id());
                        else
                            add_word(OP_W'($urandom_range(0, 3)), LOCK_ID_W'($urandom_range(0, 63)));
                    PH_DRAIN:
                        if (roll < 75)
                            add_word(OP_FREE, taken_id());
                        else if (roll < 85)
                            add_word(OP_CHECK, any_id());
                        else
                            add_word(OP_W'($urandom_range(0, 3)), LOCK_ID_W'($urandom_range(0, 63)));
                    default:
                        if (roll < 35)
                            add_word(OP_ALLOC, LOCK_ID_W'($urandom_range(0, 63)));
                        else if (roll < 65)
                            add_word(OP_FREE, (roll < 58) ? taken_id() : any_id());
                        else if (roll < 85)
                            add_word(OP_CHECK, (roll < 75) ? taken_id() : any_id());
                        else
                            add_word(OP_W'($urandom_range(0, 3)), LOCK_ID_W'($urandom_range(0, 63)));
                endcase
            end
            phase++;
        end

        // reset held low, then released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every request word gives one result word
        wait (results_seen == total_words);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_grants.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* id_free_list_allocator_core.f */
sv/ifla_pkg.sv
sv/id_free_list_allocator_core.sv
sim/tb.sv
